>>> hw/rtl/fir_dac_pkg.sv
// ----------------------------------------------------------------------------
// fir_dac_pkg
// Widths, register codes and coefficient reset values shared by the
// 16-tap FIR filter that drives an 8-bit DAC level.
// ----------------------------------------------------------------------------
package fir_dac_pkg;

  // Field widths
  localparam int SAMPLE_W = 10;
  localparam int COEF_W   = 16;
  localparam int FV_W     = 15;
  localparam int DAC_W    = 8;

  // Filter shape
  localparam int TAPS      = 16;
  localparam int TAP_IDX_W = $clog2(TAPS);
  localparam int NUM_REGS  = TAPS / 2;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int CFG_IDX_W = REG_IDX_W + 1;
  localparam int CFG_W     = 2 * COEF_W;

  // Arithmetic
  localparam int PROD_W    = SAMPLE_W + 1 + COEF_W;
  localparam int ACC_W     = SAMPLE_W + COEF_W + TAP_IDX_W;
  localparam int Q_SHIFT   = 15;
  localparam int DAC_SHIFT = 2;

  typedef logic [SAMPLE_W-1:0]  sample_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Coefficient register codes
  localparam cfg_idx_t REG_TAPS_0_1   = CFG_IDX_W'(0);
  localparam cfg_idx_t REG_TAPS_14_15 = CFG_IDX_W'(NUM_REGS - 1);

  // Reset coefficients: symmetric low-pass set, lower tap in the low half
  localparam cfg_word_t TAP_RESET [NUM_REGS] = '{
    32'd4284612494, 32'd19136373,  32'd215221674,  32'd427562110,
    32'd343808380,  32'd95030484,  32'd4285858083, 32'd4287561569
  };

endpackage

>>> hw/rtl/fir_16tap_q15_to_dac_top.sv
// ----------------------------------------------------------------------------
// fir_16tap_q15_to_dac_top
// 16-tap FIR filter on 10-bit unsigned samples with signed Q15 coefficients,
// giving a 15-bit filter value and an 8-bit clamped DAC level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / sample_in): one sample per item.
//   Output channel (out_valid / out_stall / filter_value, dac_level): one
//   result item per input item, in order.
//   Coefficient port: cfg_write with cfg_index 0..7 loads the packed tap
//   pair (lower tap in bits 15..0); indexes 8 and up are ignored.
// Timing:
//   The delay line rotates one sample per cycle past a single 11x16
//   multiplier and a 30-bit accumulator; an item goes through accept,
//   the MAC loop over all 16 taps, a product drain and a result state
//   before out_valid, and no new item is taken until its result is loaded.
//   in_stall is low only while the MAC loop is free.
// Reset:
//   rst (synchronous) clears the delay line to zeros, loads the default
//   low-pass coefficients and empties the output register.
// Stall:
//   A result waits in the output register while out_stall is high; the
//   next item is still accepted and computed, and it holds in its result
//   cycle until the output register frees.
// ----------------------------------------------------------------------------
module fir_16tap_q15_to_dac_top (
  input  logic                          clk,
  input  logic                          rst,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fir_dac_pkg::SAMPLE_W-1:0]  sample_in,
  // output channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [fir_dac_pkg::FV_W-1:0] filter_value,
  output logic [fir_dac_pkg::DAC_W-1:0]     dac_level,
  // coefficient write port
  input  logic                          cfg_write,
  input  logic [fir_dac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fir_dac_pkg::CFG_W-1:0]     cfg_data
);
  import fir_dac_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MAC   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [TAP_IDX_W-1:0] LAST_TAP = TAP_IDX_W'(TAPS - 1);

  logic [1:0]                state;
  logic [1:0]                state_next;
  logic [TAP_IDX_W-1:0]      cnt;
  sample_t                   dl [TAPS];
  cfg_word_t                 taps [NUM_REGS];
  logic signed [COEF_W-1:0]  coef;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [FV_W-1:0]    fv;
  logic [DAC_W-1:0]          dac_next;
  logic                      in_accept;
  logic                      out_load;
  cfg_word_t                 tap_word;

  assign in_accept = in_valid && !in_stall;
  assign in_stall  = (state != ST_IDLE);
  assign out_load  = (state == ST_FIN) && (!out_valid || !out_stall);

  // Coefficient registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        taps[r] <= TAP_RESET[r];
      end
    end else if (cfg_write && (cfg_index <= REG_TAPS_14_15)) begin
      taps[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Pick the coefficient of the tap at the head of the delay line
  always_comb begin
    tap_word = taps[cnt[TAP_IDX_W-1:1]];
    coef     = cnt[0] ? $signed(tap_word[CFG_W-1:COEF_W]) : $signed(tap_word[COEF_W-1:0]);
  end

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_accept) state_next = ST_MAC;
      ST_MAC:   if (cnt == LAST_TAP) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_FIN;
      ST_FIN:   if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_MAC) begin
        cnt <= cnt + TAP_IDX_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // Delay line: shift in on accept, rotate one tap per MAC cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAPS; i++) begin
        dl[i] <= '0;
      end
    end else if (in_accept) begin
      dl[0] <= sample_in;
      for (int i = 1; i < TAPS; i++) begin
        dl[i] <= dl[i-1];
      end
    end else if (state == ST_MAC) begin
      dl[TAPS-1] <= dl[0];
      for (int i = 0; i < TAPS - 1; i++) begin
        dl[i] <= dl[i+1];
      end
    end
  end

  // Multiply, then accumulate the previous tap's product
  always_ff @(posedge clk) begin
    if (state == ST_MAC) begin
      prod <= $signed({1'b0, dl[0]}) * coef;
    end
    if (in_accept) begin
      acc <= '0;
    end else if ((state == ST_MAC && cnt != '0) || state == ST_DRAIN) begin
      acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Scale and clamp
  always_comb begin
    fv = acc[Q_SHIFT +: FV_W];
    if (fv[FV_W-1]) begin
      dac_next = '0;
    end else if (fv[FV_W-2:DAC_SHIFT+DAC_W] != '0) begin
      dac_next = '1;
    end else begin
      dac_next = fv[DAC_SHIFT +: DAC_W];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filter_value <= fv;
      dac_level    <= dac_next;
    end
  end

  // Checks
  a_accept_starts_mac: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == ST_MAC && cnt == '0))
    else $error("accepted item did not start the MAC loop");

  a_mac_to_drain: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MAC && cnt == LAST_TAP) |=> (state == ST_DRAIN))
    else $error("MAC loop did not end after the last tap");

  a_negative_clamps: assert property (@(posedge clk) disable iff (rst)
    (out_valid && filter_value[FV_W-1]) |-> (dac_level == '0))
    else $error("negative filter value gave a nonzero DAC level");

  a_large_saturates: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !filter_value[FV_W-1] && filter_value[FV_W-2:DAC_SHIFT+DAC_W] != '0)
      |-> (dac_level == '1))
    else $error("large filter value did not saturate the DAC level");

  a_load_not_lost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 16-tap Q15 FIR that drives the DAC level.
// A scoreboard class keeps its own delay line and coefficient copy and
// predicts the filter value and DAC level for every accepted sample. Each
// accepted result is compared against the oldest prediction. Phases step
// through default, extreme, random and small coefficient sets, and mix
// sender gaps with receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import fir_dac_pkg::*;

  localparam int CLK_HALF         = 5;
  localparam int CYCLE_LIMIT      = 1000000;
  localparam int RANDOM_PER_PHASE = 240;
  localparam int NUM_PHASES       = 8;
  localparam int DRAIN_CYCLES     = 24;
  localparam int SAMPLE_MAX       = 2**SAMPLE_W - 1;
  localparam int DAC_MAX          = 2**DAC_W - 1;
  localparam logic [COEF_W-1:0] COEF_POS_MAX = 16'h7FFF;
  localparam logic [COEF_W-1:0] COEF_NEG_MAX = 16'h8000;

  typedef struct {
    logic signed [FV_W-1:0] fv;
    logic [DAC_W-1:0]       level;
  } fir_result_t;

  typedef enum int {
    COEF_DEFAULT, COEF_MAX, COEF_MIN, COEF_RANDOM, COEF_SMALL, COEF_MIXED
  } coef_set_e;

  // Filter predictor plus the queue of DAC results still owed by the block
  class fir_dac_checker;
    cfg_word_t   coef_regs [NUM_REGS];
    sample_t     delay_line [TAPS];
    fir_result_t pending_levels [$];
    int          mismatches;
    int          compared;
    int          samples;

    function new();
      int i;
      for (i = 0; i < NUM_REGS; i++) coef_regs[i] = TAP_RESET[i];
      for (i = 0; i < TAPS; i++) delay_line[i] = '0;
      mismatches = 0;
      compared   = 0;
      samples    = 0;
    endfunction

    // Indexes past the last register are dropped by the block
    function void write_reg(cfg_idx_t idx, cfg_word_t data);
      if (idx < NUM_REGS) coef_regs[idx] = data;
    endfunction

    // Shift the sample in, run the dot product, floor-shift and clamp
    function void filter_sample(sample_t s);
      longint                   acc;
      longint                   fv;
      logic signed [COEF_W-1:0] coef;
      fir_result_t              r;
      int                       i;
      for (i = TAPS - 1; i > 0; i--) delay_line[i] = delay_line[i-1];
      delay_line[0] = s;
      acc = 0;
      for (i = 0; i < TAPS; i++) begin
        coef = (i % 2) ? coef_regs[i/2][CFG_W-1:COEF_W] : coef_regs[i/2][COEF_W-1:0];
        acc += longint'(coef) * longint'(delay_line[i]);
      end
      fv = acc >>> Q_SHIFT;
      r.fv = fv[FV_W-1:0];
      if (fv < 0) begin
        r.level = '0;
      end else if ((fv >>> DAC_SHIFT) > DAC_MAX) begin
        r.level = DAC_W'(DAC_MAX);
      end else begin
        r.level = fv[DAC_SHIFT +: DAC_W];
      end
      pending_levels.push_back(r);
      samples++;
    endfunction

    function int outstanding();
      return pending_levels.size();
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(logic signed [FV_W-1:0] fv, logic [DAC_W-1:0] level);
      fir_result_t want;
      if (pending_levels.size() == 0) begin
        report_mismatch($sformatf("result fv=%0d level=%0d with no sample pending",
                                  fv, level));
      end else begin
        want = pending_levels.pop_front();
        compared++;
        if (fv !== want.fv)
          report_mismatch($sformatf("result %0d: filter_value %0d, want %0d",
                                    compared, fv, want.fv));
        if (level !== want.level)
          report_mismatch($sformatf("result %0d: dac_level %0d, want %0d",
                                    compared, level, want.level));
      end
    endtask
  endclass

  logic                   clk;
  logic                   rst          = 1'b1;
  logic                   in_valid     = 1'b0;
  logic                   in_stall;
  sample_t                sample_in    = '0;
  logic                   out_valid;
  logic                   out_stall    = 1'b0;
  logic signed [FV_W-1:0] filter_value;
  logic [DAC_W-1:0]       dac_level;
  logic                   cfg_write    = 1'b0;
  cfg_idx_t               cfg_index    = '0;
  cfg_word_t              cfg_data     = '0;

  int             tx_idle_pct  = 0;
  int             rx_stall_pct = 0;
  int             stall_left   = 0;
  int             cycle_count  = 0;
  fir_dac_checker chk;

  fir_16tap_q15_to_dac_top u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_in    (sample_in),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .filter_value (filter_value),
    .dac_level    (dac_level),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Observe register writes, accepted samples and accepted results
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_write) chk.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) chk.filter_sample(sample_in);
      if (out_valid && !out_stall) chk.check_result(filter_value, dac_level);
    end
  end

  // Receiver back-pressure: short bursts, now and then one longer than an item
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(99) < rx_stall_pct) begin
      out_stall <= 1'b1;
      stall_left = ($urandom_range(7) == 0) ? $urandom_range(18, 45) : $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Present one sample, with an optional gap first, and hold until taken
  task automatic send_sample(input sample_t s);
    int gap;
    gap = 0;
    if ($urandom_range(99) < tx_idle_pct)
      gap = ($urandom_range(3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Mostly uniform samples, with full-scale extremes and repeated runs
  function automatic sample_t pick_sample(sample_t prev);
    case ($urandom_range(9))
      0, 1:    return $urandom_range(1) ? sample_t'(SAMPLE_MAX) : sample_t'(0);
      2, 3:    return prev;
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] pick_half(coef_set_e kind);
    int v;
    v = 0;
    case (kind)
      COEF_MAX: return COEF_POS_MAX;
      COEF_MIN: return COEF_NEG_MAX;
      COEF_SMALL: begin
        v = int'($urandom_range(0, 4000)) - 2000;
        return v[COEF_W-1:0];
      end
      COEF_MIXED: begin
        case ($urandom_range(3))
          0:       return COEF_NEG_MAX;
          1:       return COEF_POS_MAX;
          2:       return '0;
          default: return COEF_W'($urandom);
        endcase
      end
      default: return COEF_W'($urandom);
    endcase
  endfunction

  // Load all tap pairs back to back, then one stray write past the last index
  task automatic load_coefs(input coef_set_e kind);
    int r;
    for (r = int'(REG_TAPS_0_1); r <= int'(REG_TAPS_14_15); r++) begin
      cfg_write <= 1'b1;
      cfg_index <= cfg_idx_t'(r);
      cfg_data  <= (kind == COEF_DEFAULT) ? TAP_RESET[r] : {pick_half(kind), pick_half(kind)};
      @(posedge clk);
    end
    cfg_index <= cfg_idx_t'($urandom_range(NUM_REGS, 2**CFG_IDX_W - 1));
    cfg_data  <= $urandom;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    coef_set_e plan [NUM_PHASES];
    sample_t   last;
    int        phase;
    int        n;
    int        b;
    plan = '{COEF_DEFAULT, COEF_MAX, COEF_MIN, COEF_RANDOM,
             COEF_SMALL, COEF_MIXED, COEF_DEFAULT, COEF_SMALL};
    chk = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      // The first phase runs on the reset coefficients
      if (phase > 0) load_coefs(plan[phase]);
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct <= 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct <= 59; end
        default: begin tx_idle_pct = 37; rx_stall_pct <= 37; end
      endcase

      if (phase == 0) begin
        // Walk a single set bit, then full scale until the level saturates
        for (b = 0; b < SAMPLE_W; b++) send_sample(sample_t'(1 << b));
        repeat (12) send_sample(sample_t'(SAMPLE_MAX));
        repeat (2) send_sample(sample_t'(0));
      end

      last = '0;
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        last = pick_sample(last);
        send_sample(last);
      end
      in_valid <= 1'b0;

      // Let every owed result arrive before touching the coefficients
      while (chk.outstanding() != 0) @(negedge clk);
      @(posedge clk);
    end

    tx_idle_pct = 0;
    rx_stall_pct <= 0;
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);

    $display("Filtered %0d samples over %0d coefficient sets, compared %0d results.",
             chk.samples, NUM_PHASES, chk.compared);
    $display("Covered full-scale, negative and saturating levels, stray register writes.");
    if (chk.mismatches == 0 && chk.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
